@@ rtl/assert_macros.svh @@
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/itws_pkg.sv @@
package itws_pkg;

  localparam int HIST_DEPTH = 256;
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int LEN_W      = 9;
  localparam int TS_W       = 32;
  localparam int TOT_W      = 40;
  localparam int DIV_STEPS  = TOT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int ADDR_W     = 2;
  localparam int DATA_W     = 32;

  localparam logic [LEN_W-1:0]  HIST_LEN_RST    = LEN_W'(16);
  localparam logic [ADDR_W-1:0] REG_HISTORY_LEN = '0;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STOP  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input item
    logic exec;      // apply start, or set up a stop (slot, elapsed, ring read)
    logic write;     // finish a stop: ring write, total, max, min
    logic div_init;  // load the divider with the window total
    logic div_step;  // one quotient bit
    logic load_out;  // fill the output registers
  } dp_cmd_t;

  typedef struct packed {
    logic stop_run;  // captured item is a stop while running
  } dp_status_t;

endpackage

@@ rtl/itws_dp.sv @@
module itws_dp
  import itws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [LEN_W-1:0]     history_len,
  input  logic                 in_cmd,
  input  logic                 in_clear_history,
  input  logic [TS_W-1:0]      in_now_ms,
  output logic                 out_running,
  output logic [TS_W-1:0]      out_average_ms,
  output logic [TS_W-1:0]      out_max_ms,
  output logic [TS_W-1:0]      out_min_ms
);

  // captured item
  logic              cmd_r;
  logic              clr_r;
  logic [TS_W-1:0]   now_r;

  // measurement state
  logic              run_r, run_nxt;
  logic [TS_W-1:0]   stamp_r, stamp_nxt;
  logic [TS_W-1:0]   max_r, max_nxt;
  logic [TS_W-1:0]   min_r, min_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [HIST_DEPTH-1:0] valid_r, valid_nxt;

  logic [PTR_W-1:0]  slot_r;
  logic [TS_W-1:0]   elapsed_r;
  logic [TS_W-1:0]   rd_data_r;
  logic [TS_W-1:0]   ring_mem [HIST_DEPTH];

  // divider
  logic [LEN_W-1:0]  rem_r;
  logic [TOT_W-1:0]  quo_r;
  logic [LEN_W:0]    div_sh;
  logic              div_bit;

  logic [LEN_W-1:0]  len_w;
  logic [PTR_W-1:0]  slot_sel;
  logic [TS_W-1:0]   old_val;
  logic [LEN_W-1:0]  slot_inc;

  always_comb begin
    if (history_len == '0) begin
      len_w = LEN_W'(1);
    end else if (history_len > LEN_W'(HIST_DEPTH)) begin
      len_w = LEN_W'(HIST_DEPTH);
    end else begin
      len_w = history_len;
    end
  end

  assign status.stop_run = (cmd_r == CMD_STOP) && run_r;

  // a pointer left beyond a lowered length wraps to entry 0
  assign slot_sel = ({1'b0, ptr_r} < len_w) ? ptr_r : '0;
  assign old_val  = valid_r[slot_r] ? rd_data_r : '0;
  assign slot_inc = {1'b0, slot_r} + LEN_W'(1);

  always_comb begin
    run_nxt   = run_r;
    stamp_nxt = stamp_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    total_nxt = total_r;
    ptr_nxt   = ptr_r;
    valid_nxt = valid_r;
    if (cmd.exec && cmd_r == CMD_START) begin
      if (clr_r) begin
        max_nxt   = '0;
        min_nxt   = '1;
        total_nxt = '0;
        ptr_nxt   = '0;
        valid_nxt = '0;
      end
      stamp_nxt = now_r;
      run_nxt   = 1'b1;
    end
    if (cmd.write) begin
      total_nxt         = total_r - TOT_W'(old_val) + TOT_W'(elapsed_r);
      valid_nxt[slot_r] = 1'b1;
      ptr_nxt           = (slot_inc >= len_w) ? '0 : slot_inc[PTR_W-1:0];
      if (elapsed_r > max_r) max_nxt = elapsed_r;
      if (elapsed_r < min_r) min_nxt = elapsed_r;
      run_nxt           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      stamp_r <= '0;
      max_r   <= '0;
      min_r   <= '1;
      total_r <= '0;
      ptr_r   <= '0;
      valid_r <= '0;
    end else begin
      run_r   <= run_nxt;
      stamp_r <= stamp_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      total_r <= total_nxt;
      ptr_r   <= ptr_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      clr_r <= in_clear_history;
      now_r <= in_now_ms;
    end
    if (cmd.exec) begin
      slot_r    <= slot_sel;
      elapsed_r <= now_r - stamp_r;
      rd_data_r <= ring_mem[slot_sel];
    end
    if (cmd.write) begin
      ring_mem[slot_r] <= elapsed_r;
    end
  end

  // restoring divide, one quotient bit per step
  assign div_sh  = {rem_r, quo_r[TOT_W-1]};
  assign div_bit = (div_sh >= {1'b0, len_w});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= total_r;
    end else if (cmd.div_step) begin
      rem_r <= div_bit ? LEN_W'(div_sh - {1'b0, len_w}) : div_sh[LEN_W-1:0];
      quo_r <= {quo_r[TOT_W-2:0], div_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_running    <= run_r;
      out_average_ms <= (|quo_r[TOT_W-1:TS_W]) ? '1 : quo_r[TS_W-1:0];
      out_max_ms     <= max_r;
      out_min_ms     <= min_r;
    end
  end

endmodule

@@ rtl/itws_ctrl.sv @@
`include "assert_macros.svh"

module itws_ctrl
  import itws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_WRITE = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.capture = in_valid && in_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.stop_run ? ST_WRITE : ST_DIV;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // a count of zero loads the divider, then one bit per cycle
        if (cnt_r == '0) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        if (cnt_r == DIV_CNT_W'(DIV_STEPS)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + DIV_CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_r == ST_EXEC, "accepted item did not start")
  `ASSERT_CLK(a_div_cnt, (state_r == ST_DIV) |-> (cnt_r <= DIV_CNT_W'(DIV_STEPS)), "divide count overrun")
  `ASSERT_NEXT(a_load_out, cmd.load_out, out_valid_r && state_r == ST_IDLE, "result load lost")
  `ASSERT_CLK(a_idle_cnt, (state_r != ST_DIV) |-> (cnt_r == '0), "divide count not cleared")

endmodule

@@ rtl/interval_timer_window_stats_top.sv @@
// Interval timer with moving-window statistics.
// Input channel (in_valid/in_ready): in_cmd is start or stop, in_clear_history
// clears max, min, total and the history ring on a start, in_now_ms is the
// current millisecond timestamp. A stop while running stores the elapsed time
// in a ring of history_len entries (0 is taken as 1, above 256 as 256). Every
// item yields one result on the output channel (out_valid/out_ready): running
// flag, window average, max, min. history_len is written through the APB-style
// port at address 0 while idle; the user must keep to this, the block does not
// enforce it. One item is in flight at a time: an accepted item passes the exec
// state, the write state for a stop while running, the divide state (a load,
// then 40 bit-serial steps) and the done state before the next is accepted.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and only its final load waits while out_ready is low.
// Reset (synchronous, rst_n low) sets history_len to 16, clears the statistics,
// the running flag and all ring valid bits; no clearing pass is needed.
module interval_timer_window_stats_top
  import itws_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic              in_clear_history,
  input  logic [TS_W-1:0]   in_now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_running,
  output logic [TS_W-1:0]   out_average_ms,
  output logic [TS_W-1:0]   out_max_ms,
  output logic [TS_W-1:0]   out_min_ms
);

  logic [LEN_W-1:0] hist_len_r;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_HISTORY_LEN) ? DATA_W'(hist_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r <= HIST_LEN_RST;
    end else if (psel && penable && pwrite && pready && paddr == REG_HISTORY_LEN) begin
      hist_len_r <= pwdata[LEN_W-1:0];
    end
  end

  itws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  itws_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .history_len      (hist_len_r),
    .in_cmd           (in_cmd),
    .in_clear_history (in_clear_history),
    .in_now_ms        (in_now_ms),
    .out_running      (out_running),
    .out_average_ms   (out_average_ms),
    .out_max_ms       (out_max_ms),
    .out_min_ms       (out_min_ms)
  );

endmodule

@@ sim/interval_timer_window_stats_top_tb.sv @@
`timescale 1ns / 100ps

module interval_timer_window_stats_top_tb;
  import itws_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic            cmd;
    logic            clr;
    logic [TS_W-1:0] now;
  } timer_item_t;

  typedef struct packed {
    logic            running;
    logic [TS_W-1:0] avg;
    logic [TS_W-1:0] max;
    logic [TS_W-1:0] min;
  } timer_stats_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_cmd = 1'b0;
  logic              in_clear_history = 1'b0;
  logic [TS_W-1:0]   in_now_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_running;
  logic [TS_W-1:0]   out_average_ms;
  logic [TS_W-1:0]   out_max_ms;
  logic [TS_W-1:0]   out_min_ms;

  interval_timer_window_stats_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_clear_history (in_clear_history),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_running      (out_running),
    .out_average_ms   (out_average_ms),
    .out_max_ms       (out_max_ms),
    .out_min_ms       (out_min_ms)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  timer_item_t  pending_items[$];
  timer_stats_t stats_expected[$];
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           mismatch_cnt = 0;
  int           cycle_cnt = 0;
  logic         in_taken = 1'b0;

  // predictor state
  logic [LEN_W-1:0] hist_len_cfg = HIST_LEN_RST;
  logic [TS_W-1:0]  tmr_stamp = '0;
  logic             tmr_running = 1'b0;
  logic [TS_W-1:0]  stat_max = '0;
  logic [TS_W-1:0]  stat_min = '1;
  logic [47:0]      win_total = '0;
  int unsigned      wr_ptr = 0;
  logic [TS_W-1:0]  hist_ring [HIST_DEPTH];
  logic             hist_valid [HIST_DEPTH];

  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_ring[i] = '0;
      hist_valid[i] = 1'b0;
    end
  end

  function automatic void predict_stats(logic cmd, logic clr, logic [TS_W-1:0] now);
    int unsigned     eff;
    int unsigned     slot;
    logic [TS_W-1:0] elapsed;
    logic [TS_W-1:0] old;
    logic [47:0]     quo;
    timer_stats_t    s;
    eff = 32'(hist_len_cfg);
    if (eff < 1) eff = 1;
    if (eff > HIST_DEPTH) eff = HIST_DEPTH;
    if (cmd == CMD_START) begin
      if (clr) begin
        stat_max = '0;
        stat_min = '1;
        win_total = '0;
        wr_ptr = 0;
        for (int i = 0; i < HIST_DEPTH; i++) hist_valid[i] = 1'b0;
      end
      tmr_stamp = now;
      tmr_running = 1'b1;
    end else if (tmr_running) begin
      elapsed = now - tmr_stamp;
      // pointer left past the end by a lowered length restarts at entry 0
      slot = (wr_ptr < eff) ? wr_ptr : 0;
      old = hist_valid[slot] ? hist_ring[slot] : '0;
      win_total = win_total - 48'(old) + 48'(elapsed);
      hist_ring[slot] = elapsed;
      hist_valid[slot] = 1'b1;
      wr_ptr = (slot + 1 >= eff) ? 0 : slot + 1;
      if (elapsed > stat_max) stat_max = elapsed;
      if (elapsed < stat_min) stat_min = elapsed;
      tmr_running = 1'b0;
    end
    quo = win_total / 48'(eff);
    s.running = tmr_running;
    s.avg = (quo > 48'hFFFF_FFFF) ? '1 : quo[TS_W-1:0];
    s.max = stat_max;
    s.min = stat_min;
    stats_expected.push_back(s);
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] exp);
    $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, exp);
    mismatch_cnt++;
  endtask

  // driver
  always @(negedge clk) begin
    timer_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (!in_valid || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          in_cmd <= it.cmd;
          in_clear_history <= it.clr;
          in_now_ms <= it.now;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    timer_stats_t e;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (stats_expected.size() == 0) begin
          report_mismatch("result with nothing pending", DATA_W'(out_average_ms), '0);
        end else begin
          e = stats_expected.pop_front();
          if (out_running !== e.running)
            report_mismatch("running", DATA_W'(out_running), DATA_W'(e.running));
          if (out_average_ms !== e.avg) report_mismatch("average_ms", out_average_ms, e.avg);
          if (out_max_ms !== e.max) report_mismatch("max_ms", out_max_ms, e.max);
          if (out_min_ms !== e.min) report_mismatch("min_ms", out_min_ms, e.min);
        end
      end
      if (in_valid && in_ready) predict_stats(in_cmd, in_clear_history, in_now_ms);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_item(input logic cmd, input logic clr, input logic [TS_W-1:0] now);
    timer_item_t it;
    it.cmd = cmd;
    it.clr = clr;
    it.now = now;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || stats_expected.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_history_len(input int unsigned val);
    logic [DATA_W-1:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_HISTORY_LEN;
    pwdata <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    hist_len_cfg = val[LEN_W-1:0];
    // read it back
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== DATA_W'(hist_len_cfg)) report_mismatch("history_len readback", got,
                                                       DATA_W'(hist_len_cfg));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // start/stop pairs with random content, plus loose commands as noise
  task automatic queue_random(input int n);
    int              made;
    logic [TS_W-1:0] t0;
    logic [TS_W-1:0] dt;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 15) begin
        push_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
        made++;
      end else begin
        t0 = $urandom;
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: dt = $urandom_range(5000);
          6, 7:             dt = $urandom;
          8:                dt = 32'hFFFF_FFFF - $urandom_range(15);
          default:          dt = $urandom_range(3);
        endcase
        push_item(CMD_START, ($urandom_range(31) == 0), t0);
        push_item(CMD_STOP, 1'($urandom_range(1)), t0 + dt);
        made += 2;
      end
    end
  endtask

  task automatic run_phase(input int unsigned len, input int send_pct, input int stall,
                           input int n);
    wait_idle();
    write_history_len(len);
    send_idle_pct = send_pct;
    stall_pct = stall;
    queue_random(n);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, at the reset length
    push_item(CMD_STOP, 1'b0, 32'h0000_0000);        // stop while idle
    push_item(CMD_START, 1'b1, 32'hFFFF_FFF0);
    push_item(CMD_START, 1'b0, 32'hFFFF_FFFF);       // restart while running
    push_item(CMD_STOP, 1'b1, 32'h0000_000A);        // timestamp wrap, partial window
    push_item(CMD_START, 1'b0, 32'h0000_0000);
    push_item(CMD_STOP, 1'b0, 32'hFFFF_FFFF);        // largest interval
    push_item(CMD_START, 1'b0, 32'h5555_5555);
    push_item(CMD_STOP, 1'b0, 32'h5555_5555);        // zero interval
    push_item(CMD_STOP, 1'b0, 32'hAAAA_AAAA);
    wait_idle();
    // pointer now sits past the shorter ring, stale entry stays in the total
    write_history_len(2);
    push_item(CMD_START, 1'b0, 32'h0000_0000);
    push_item(CMD_STOP, 1'b0, 32'hFFFF_FFFF);
    push_item(CMD_START, 1'b0, 32'h0000_0000);
    push_item(CMD_STOP, 1'b0, 32'hFFFF_FFFF);
    wait_idle();
    write_history_len(1);                            // average saturates
    push_item(CMD_STOP, 1'b0, 32'h1234_5678);
    wait_idle();
    write_history_len(0);                            // treated as one entry
    push_item(CMD_START, 1'b0, 32'h0000_0007);
    push_item(CMD_STOP, 1'b0, 32'h0000_006B);
    push_item(CMD_START, 1'b1, 32'h8000_0000);
    push_item(CMD_STOP, 1'b0, 32'h8000_0003);
    wait_idle();
    write_history_len(511);                          // clamped to full depth
    push_item(CMD_START, 1'b1, 32'h0000_0100);
    push_item(CMD_STOP, 1'b0, 32'h0001_0100);

    run_phase(1, 0, 0, 50);
    run_phase(5, 84, 0, 50);
    run_phase(511, 0, 84, 50);
    run_phase($urandom_range(511), 14, 14, 50);
    run_phase(3, 0, 0, 50);
    run_phase(HIST_DEPTH, 0, 0, 200);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stats_expected.size() != 0)
      report_mismatch("results never seen", DATA_W'(stats_expected.size()), '0);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/itws_pkg.sv
rtl/itws_dp.sv
rtl/itws_ctrl.sv
rtl/interval_timer_window_stats_top.sv
sim/interval_timer_window_stats_top_tb.sv
